// ===== sv/ac3rtp_pkg.sv =====
// Package: shared constants and controller/datapath interface types.
`timescale 1ns / 1ps
package ac3rtp_pkg;

    localparam int MTU_W        = 14;
    localparam int LEN_W        = 13;
    localparam int OFF_W        = 12;
    localparam int CNT_W        = 6;
    localparam int DIV_STEP_W   = 4;

    localparam logic [MTU_W-1:0] MTU_RESET = 14'd1500;
    localparam logic [MTU_W-1:0] MTU_MIN   = 14'd72;
    localparam logic [MTU_W-1:0] MTU_MAX   = 14'd9000;
    localparam logic [MTU_W-1:0] HDR_BYTES = 14'd2;

    localparam logic [CNT_W-1:0] MAX_RESULTS = 6'd59;

    localparam logic [0:0] REG_MTU   = 1'b0;
    localparam logic [0:0] REG_DRAFT = 1'b1;

    localparam logic [7:0] DRAFT_NDU      = 8'd1;
    localparam logic [7:0] FT_WHOLE       = 8'd0;
    localparam logic [7:0] FT_FIRST_FIVE  = 8'd1;
    localparam logic [7:0] FT_FIRST_OTHER = 8'd2;
    localparam logic [7:0] FT_LATER       = 8'd3;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit;
    } ac3rtp_cmd_t;

    typedef struct packed {
        logic unfrag;
        logic div_last;
        logic last;
    } ac3rtp_status_t;

endpackage

// ===== sv/ac3rtp_if.sv =====
// Interfaces: frame input channel and packet descriptor output channel.
`timescale 1ns / 1ps
interface ac3rtp_frame_if;
    logic        valid;
    logic        ready;
    logic [12:0] frame_length;
    logic        in_frame_start;
    logic        in_frame_end;

    modport source (output valid, frame_length, in_frame_start, in_frame_end, input ready);
    modport sink (input valid, frame_length, in_frame_start, in_frame_end, output ready);
endinterface

interface ac3rtp_pkt_if;
    logic        valid;
    logic        ready;
    logic [7:0]  header_byte0;
    logic [7:0]  header_byte1;
    logic [11:0] payload_offset;
    logic [12:0] payload_length;
    logic        out_frame_start;
    logic        out_frame_end;
    logic        last_packet;

    modport source (output valid, header_byte0, header_byte1, payload_offset,
                    payload_length, out_frame_start, out_frame_end, last_packet,
                    input ready);
    modport sink (input valid, header_byte0, header_byte1, payload_offset,
                  payload_length, out_frame_start, out_frame_end, last_packet,
                  output ready);
endinterface

// ===== sv/ac3rtp_ctrl.sv =====
// Controller: sequences load, fragment-count division and descriptor emission.
`timescale 1ns / 1ps
module ac3rtp_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  ac3rtp_pkg::ac3rtp_status_t status,
    output ac3rtp_pkg::ac3rtp_cmd_t    cmd
);
    import ac3rtp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        cmd.load     = in_valid && in_ready;
        cmd.div_step = (state_reg == ST_DIV);
        cmd.emit     = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
        out_valid    = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.load)
                        state_reg <= status.unfrag ? ST_EMIT : ST_DIV;
                end
                ST_DIV:
                begin
                    if (status.div_last)
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (cmd.emit && status.last)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/ac3rtp_dp.sv =====
// Datapath: config registers, bit-serial fragment divider, descriptor generation.
`timescale 1ns / 1ps
module ac3rtp_dp
#(
    parameter int MAX_FRAME_BYTES = 4096
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [0:0]                wr_index,
    input  logic [13:0]               wr_data,
    input  logic [12:0]               frame_length,
    input  logic                      in_frame_start,
    input  logic                      in_frame_end,
    input  ac3rtp_pkg::ac3rtp_cmd_t   cmd,
    output ac3rtp_pkg::ac3rtp_status_t status,
    output logic [7:0]                header_byte0,
    output logic [7:0]                header_byte1,
    output logic [11:0]               payload_offset,
    output logic [12:0]               payload_length,
    output logic                      out_frame_start,
    output logic                      out_frame_end,
    output logic                      last_packet
);
    import ac3rtp_pkg::*;

    localparam logic [16:0] MAX_LEN = 17'(MAX_FRAME_BYTES);

    logic [MTU_W-1:0]      mtu_reg;
    logic                  draft_reg;

    logic [LEN_W-1:0]      len_reg;
    logic [MTU_W-1:0]      room_reg;
    logic                  fs_reg;
    logic                  fe_reg;
    logic                  unfrag_reg;
    logic                  five_reg;
    logic [MTU_W-1:0]      rem_reg;
    logic [LEN_W-1:0]      quo_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [LEN_W-1:0]      off_reg;
    logic [CNT_W-1:0]      k_reg;

    logic [7:0]            hb0_reg;
    logic [7:0]            hb1_reg;
    logic [OFF_W-1:0]      poff_reg;
    logic [LEN_W-1:0]      plen_reg;
    logic                  pfs_reg;
    logic                  pfe_reg;
    logic                  plast_reg;

    // load-time values
    logic [MTU_W-1:0]      m_clamp;
    logic [MTU_W-1:0]      room_in;
    logic [LEN_W-1:0]      len_in;
    logic                  unfrag_in;
    logic                  five_in;

    // divider step
    logic [MTU_W:0]        trial;
    logic                  q_bit;

    // emission
    logic [LEN_W-1:0]      rest;
    logic [LEN_W-1:0]      w;
    logic                  fits;
    logic                  first;
    logic                  last;
    logic [LEN_W-1:0]      frags;
    logic [7:0]            b0;
    logic [7:0]            b1;

    always_comb
    begin
        if (mtu_reg < MTU_MIN)
            m_clamp = MTU_MIN;
        else if (mtu_reg > MTU_MAX)
            m_clamp = MTU_MAX;
        else
            m_clamp = mtu_reg;
        room_in = m_clamp - HDR_BYTES;

        if (17'(frame_length) > MAX_LEN)
            len_in = MAX_LEN[LEN_W-1:0];
        else
            len_in = frame_length;

        unfrag_in = ((MTU_W)'(len_in) + HDR_BYTES) <= m_clamp;
        five_in   = ({room_in, 3'b000}) >= (17'(len_in) * 17'd5);

        trial = {rem_reg, quo_reg[LEN_W-1]};
        q_bit = trial >= {1'b0, room_reg};

        rest  = len_reg - off_reg;
        fits  = {1'b0, rest} <= room_reg;
        w     = fits ? rest : room_reg[LEN_W-1:0];
        first = (k_reg == '0);
        last  = fits || (k_reg == MAX_RESULTS - 6'd1);
        frags = unfrag_reg ? 13'd1 : quo_reg + 13'd1;

        if (draft_reg)
        begin
            b0 = DRAFT_NDU;
            b1 = {2'b00, !unfrag_reg, first && five_reg, 4'b0000};
        end
        else
        begin
            if (unfrag_reg)
                b0 = FT_WHOLE;
            else if (!first)
                b0 = FT_LATER;
            else
                b0 = five_reg ? FT_FIRST_FIVE : FT_FIRST_OTHER;
            b1 = frags[7:0];
        end

        status.unfrag   = unfrag_in;
        status.div_last = (step_reg == '0);
        status.last     = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtu_reg   <= MTU_RESET;
            draft_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MTU:   mtu_reg   <= wr_data;
                REG_DRAFT: draft_reg <= wr_data[0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            len_reg    <= len_in;
            room_reg   <= room_in;
            fs_reg     <= in_frame_start;
            fe_reg     <= in_frame_end;
            unfrag_reg <= unfrag_in;
            five_reg   <= unfrag_in || five_in;
            rem_reg    <= '0;
            quo_reg    <= len_in - 13'd1;
            step_reg   <= DIV_STEP_W'(LEN_W - 1);
            off_reg    <= '0;
            k_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= q_bit ? MTU_W'(trial - {1'b0, room_reg}) : trial[MTU_W-1:0];
            quo_reg  <= {quo_reg[LEN_W-2:0], q_bit};
            step_reg <= step_reg - 4'd1;
        end
        else if (cmd.emit)
        begin
            hb0_reg   <= b0;
            hb1_reg   <= b1;
            poff_reg  <= off_reg[OFF_W-1:0];
            plen_reg  <= w;
            pfs_reg   <= fs_reg && first;
            pfe_reg   <= fe_reg && last;
            plast_reg <= last;
            off_reg   <= off_reg + w;
            k_reg     <= k_reg + 6'd1;
        end
    end

    assign header_byte0    = hb0_reg;
    assign header_byte1    = hb1_reg;
    assign payload_offset  = poff_reg;
    assign payload_length  = plen_reg;
    assign out_frame_start = pfs_reg;
    assign out_frame_end   = pfe_reg;
    assign last_packet     = plast_reg;

endmodule

// ===== sv/ac3_rtp_fragment_header_gen_top.sv =====
// Top level: AC-3 RTP packetizer emitting one descriptor per RTP packet.
// Sequence: an unfragmented frame goes from load to descriptor emission directly;
// a fragmented frame first runs the 13-step restoring divider for the fragment count.
// Throughput: one descriptor per cycle while the output is taken;
// one frame at a time.
// Reset: asynchronous active low; mtu = 1500, draft_mode = 1, channels idle.
`timescale 1ns / 1ps
module ac3_rtp_fragment_header_gen_top
#(
    parameter int MAX_FRAME_BYTES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [0:0]  wr_index,
    input  logic [13:0] wr_data,
    ac3rtp_frame_if.sink  frame_ch,
    ac3rtp_pkt_if.source  pkt_ch
);
    import ac3rtp_pkg::*;

    ac3rtp_cmd_t    cmd;
    ac3rtp_status_t status;

    ac3rtp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frame_ch.valid),
        .in_ready  (frame_ch.ready),
        .out_valid (pkt_ch.valid),
        .out_ready (pkt_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    ac3rtp_dp #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .frame_length    (frame_ch.frame_length),
        .in_frame_start  (frame_ch.in_frame_start),
        .in_frame_end    (frame_ch.in_frame_end),
        .cmd             (cmd),
        .status          (status),
        .header_byte0    (pkt_ch.header_byte0),
        .header_byte1    (pkt_ch.header_byte1),
        .payload_offset  (pkt_ch.payload_offset),
        .payload_length  (pkt_ch.payload_length),
        .out_frame_start (pkt_ch.out_frame_start),
        .out_frame_end   (pkt_ch.out_frame_end),
        .last_packet     (pkt_ch.last_packet)
    );

endmodule
